// File: hdl/spct_pkg.sv
// shared constants and types for the proximity carve test block
package spct_pkg;

    localparam int DEF_MAX_ANCHORS = 1024;
    localparam int DEF_COORD_BITS  = 24;

    localparam int RADIUS_BITS  = 23;
    localparam int SQ_BITS      = 2 * RADIUS_BITS;
    localparam int ACC_BITS     = SQ_BITS + 2;
    localparam int CFG_IDX_BITS = 1;

    typedef logic [1:0] t_func;

    localparam t_func FUNC_LOAD  = 2'd0;
    localparam t_func FUNC_QUERY = 2'd1;
    localparam t_func FUNC_CLEAR = 2'd2;

    typedef logic [CFG_IDX_BITS-1:0] t_cfg_idx;

    localparam t_cfg_idx CFG_CUTOFF_RADIUS = 1'd0;
    localparam t_cfg_idx CFG_AVOID_MODE    = 1'd1;

endpackage

// File: hdl/spct_sqr.sv
// shared registered squaring unit
module spct_sqr (
    input  logic                            i_clk,
    input  logic [spct_pkg::RADIUS_BITS-1:0] i_op,
    output logic [spct_pkg::SQ_BITS-1:0]     o_prod
);
    import spct_pkg::*;

    logic [SQ_BITS-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= SQ_BITS'(i_op) * SQ_BITS'(i_op);
    end

    assign o_prod = r_prod;

endmodule

// File: hdl/sphere_proximity_carve_test.sv
// top level of the fixed radius anchor proximity test
//
// an item is taken when start is high and busy is low; i_func selects load,
// query or clear of the anchor store. load and clear finish in the transfer
// cycle itself and leave busy low. a query raises busy and scans the anchor
// store at most once per vertex, one anchor at a time, through one memory read
// port and one shared squaring multiplier. an anchor is rejected on the first
// axis whose distance exceeds the radius, else the squared distances of all
// three axes are summed and compared with the squared radius. the scan of a
// vertex ends at the first anchor within range; a vertex with none ends the query.
// its result is shown on o_excluded, o_all_within and o_store_overflow with
// o_done high for exactly one cycle; busy drops in the following cycle.
// the receiver cannot stall, so nothing waits on the output side.
// configuration writes go through i_cfg_valid and o_cfg_ready, which is
// always high; register 0 is the cutoff radius and register 1 avoid mode.
// synchronous active low reset empties the store, clears the overflow flag
// and the registers; anchor memory contents are not cleared.
module sphere_proximity_carve_test #(
    parameter int MAX_ANCHORS = spct_pkg::DEF_MAX_ANCHORS,
    parameter int COORD_BITS  = spct_pkg::DEF_COORD_BITS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  spct_pkg::t_func                   i_func,
    input  logic [1:0]                        i_vertex_count,
    input  logic signed [COORD_BITS-1:0]      i_x0,
    input  logic signed [COORD_BITS-1:0]      i_y0,
    input  logic signed [COORD_BITS-1:0]      i_z0,
    input  logic signed [COORD_BITS-1:0]      i_x1,
    input  logic signed [COORD_BITS-1:0]      i_y1,
    input  logic signed [COORD_BITS-1:0]      i_z1,
    input  logic signed [COORD_BITS-1:0]      i_x2,
    input  logic signed [COORD_BITS-1:0]      i_y2,
    input  logic signed [COORD_BITS-1:0]      i_z2,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  spct_pkg::t_cfg_idx                i_cfg_index,
    input  logic [spct_pkg::RADIUS_BITS-1:0]  i_cfg_data,
    output logic                              o_done,
    output logic                              o_excluded,
    output logic                              o_all_within,
    output logic                              o_store_overflow
);
    import spct_pkg::*;

    localparam int AW = (MAX_ANCHORS > 1) ? $clog2(MAX_ANCHORS) : 1;
    localparam int CW = $clog2(MAX_ANCHORS + 1);
    localparam int EW = 3 * COORD_BITS;
    localparam int DW = (COORD_BITS + 1 > RADIUS_BITS) ? COORD_BITS + 1 : RADIUS_BITS;

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_RSQ  = 8'b0000_0010,
        S_RSQW = 8'b0000_0100,
        S_READ = 8'b0000_1000,
        S_DIFF = 8'b0001_0000,
        S_SQR  = 8'b0010_0000,
        S_ACC  = 8'b0100_0000,
        S_DONE = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;

    logic [EW-1:0] r_mem [MAX_ANCHORS];
    logic [EW-1:0] r_rd;

    logic [RADIUS_BITS-1:0] r_radius;
    logic                   r_avoid;
    logic [CW-1:0]          r_count;
    logic                   r_ovf;

    logic signed [COORD_BITS-1:0] r_vx [3];
    logic signed [COORD_BITS-1:0] r_vy [3];
    logic signed [COORD_BITS-1:0] r_vz [3];
    logic [1:0]                   r_nvert;

    logic [1:0]             r_vidx, n_vidx;
    logic [CW-1:0]          r_aidx, n_aidx;
    logic [1:0]             r_axis, n_axis;
    logic [ACC_BITS-1:0]    r_acc, n_acc;
    logic [SQ_BITS-1:0]     r_r2, n_r2;
    logic [RADIUS_BITS-1:0] r_dabs, n_dabs;
    logic                   r_within, n_within;

    logic                   accept;
    logic                   at_last_anchor;
    logic                   at_last_vertex;
    logic signed [COORD_BITS-1:0] ca, cv;
    logic signed [COORD_BITS:0]   diff;
    logic [COORD_BITS:0]          mag;
    logic                         far;
    logic [RADIUS_BITS-1:0]       sq_op;
    logic [SQ_BITS-1:0]           sq_prod;
    logic [ACC_BITS-1:0]          sum;

    assign accept         = start && !busy;
    assign busy           = (r_state != S_IDLE);
    assign o_cfg_ready    = 1'b1;
    assign at_last_anchor = ((r_aidx + CW'(1)) == r_count);
    assign at_last_vertex = ((r_vidx + 2'd1) == r_nvert);

    always_ff @(posedge i_clk) begin
        if (accept && i_func == FUNC_LOAD && r_count < CW'(MAX_ANCHORS)) begin
            r_mem[r_count[AW-1:0]] <= {i_z0, i_y0, i_x0};
        end
        r_rd <= r_mem[r_aidx[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius <= '0;
            r_avoid  <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_CUTOFF_RADIUS: r_radius <= i_cfg_data;
                CFG_AVOID_MODE:    r_avoid  <= i_cfg_data[0];
                default:           r_avoid  <= r_avoid;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_ovf   <= 1'b0;
        end else if (accept) begin
            case (i_func)
                FUNC_LOAD: begin
                    if (r_count < CW'(MAX_ANCHORS)) begin
                        r_count <= r_count + CW'(1);
                    end else begin
                        r_ovf <= 1'b1;
                    end
                end
                FUNC_CLEAR: begin
                    r_count <= '0;
                    r_ovf   <= 1'b0;
                end
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && i_func == FUNC_QUERY) begin
            r_vx[0] <= i_x0;
            r_vy[0] <= i_y0;
            r_vz[0] <= i_z0;
            r_vx[1] <= i_x1;
            r_vy[1] <= i_y1;
            r_vz[1] <= i_z1;
            r_vx[2] <= i_x2;
            r_vy[2] <= i_y2;
            r_vz[2] <= i_z2;
            r_nvert <= (i_vertex_count == 2'd0) ? 2'd1 : i_vertex_count;
        end
    end

    // axis operand select and magnitude of the difference
    always_comb begin
        case (r_axis)
            2'd1: begin
                ca = r_rd[2*COORD_BITS-1:COORD_BITS];
                cv = r_vy[r_vidx];
            end
            2'd2: begin
                ca = r_rd[3*COORD_BITS-1:2*COORD_BITS];
                cv = r_vz[r_vidx];
            end
            default: begin
                ca = r_rd[COORD_BITS-1:0];
                cv = r_vx[r_vidx];
            end
        endcase
        diff = {ca[COORD_BITS-1], ca} - {cv[COORD_BITS-1], cv};
        mag  = diff[COORD_BITS] ? (COORD_BITS+1)'(-diff) : (COORD_BITS+1)'(diff);
        far  = DW'(mag) > DW'(r_radius);
    end

    assign sq_op = (r_state == S_RSQ) ? r_radius : r_dabs;
    assign sum   = r_acc + ACC_BITS'(sq_prod);

    spct_sqr u_sqr (
        .i_clk  (i_clk),
        .i_op   (sq_op),
        .o_prod (sq_prod)
    );

    always_comb begin
        n_state  = r_state;
        n_vidx   = r_vidx;
        n_aidx   = r_aidx;
        n_axis   = r_axis;
        n_acc    = r_acc;
        n_r2     = r_r2;
        n_dabs   = r_dabs;
        n_within = r_within;
        case (r_state)
            S_IDLE: begin
                if (accept && i_func == FUNC_QUERY) begin
                    n_vidx  = 2'd0;
                    n_aidx  = '0;
                    n_state = S_RSQ;
                end
            end
            S_RSQ: begin
                n_state = S_RSQW;
            end
            S_RSQW: begin
                n_r2 = sq_prod;
                if (r_count == '0) begin
                    n_within = 1'b0;
                    n_state  = S_DONE;
                end else begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                n_axis  = 2'd0;
                n_acc   = '0;
                n_state = S_DIFF;
            end
            S_DIFF: begin
                if (far) begin
                    if (at_last_anchor) begin
                        n_within = 1'b0;
                        n_state  = S_DONE;
                    end else begin
                        n_aidx  = r_aidx + CW'(1);
                        n_state = S_READ;
                    end
                end else begin
                    n_dabs  = RADIUS_BITS'(mag);
                    n_state = S_SQR;
                end
            end
            S_SQR: begin
                n_state = S_ACC;
            end
            S_ACC: begin
                if (r_axis != 2'd2) begin
                    n_acc   = sum;
                    n_axis  = r_axis + 2'd1;
                    n_state = S_DIFF;
                end else if (sum <= ACC_BITS'(r_r2)) begin
                    if (at_last_vertex) begin
                        n_within = 1'b1;
                        n_state  = S_DONE;
                    end else begin
                        n_vidx  = r_vidx + 2'd1;
                        n_aidx  = '0;
                        n_state = S_READ;
                    end
                end else if (at_last_anchor) begin
                    n_within = 1'b0;
                    n_state  = S_DONE;
                end else begin
                    n_aidx  = r_aidx + CW'(1);
                    n_state = S_READ;
                end
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_vidx   <= 2'd0;
            r_aidx   <= '0;
            r_axis   <= 2'd0;
            r_within <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_vidx   <= n_vidx;
            r_aidx   <= n_aidx;
            r_axis   <= n_axis;
            r_within <= n_within;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc  <= n_acc;
        r_r2   <= n_r2;
        r_dabs <= n_dabs;
    end

    assign o_done           = (r_state == S_DONE);
    assign o_all_within     = r_within;
    assign o_excluded       = r_avoid ? r_within : !r_within;
    assign o_store_overflow = r_ovf;

`ifndef SYNTHESIS
    a_done_single : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe longer than one cycle");

    a_count_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_ANCHORS))
        else $error("anchor count past capacity");

    a_query_busy : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_func == FUNC_QUERY) |=> busy)
        else $error("query transfer did not start a scan");

    a_scan_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIFF || r_state == S_ACC) |-> (r_aidx < r_count && r_vidx < r_nvert))
        else $error("scan index outside the store or vertex list");

    a_store_stable : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (busy && $past(busy)) |-> $stable(r_count))
        else $error("anchor count changed during a query");
`endif

endmodule
